// File: design/uniform_range_rejection_mapper_core_assert.svh
// Assertion macros used by the range mapper RTL.
`ifndef UNIFORM_RANGE_REJECTION_MAPPER_CORE_ASSERT_SVH
`define UNIFORM_RANGE_REJECTION_MAPPER_CORE_ASSERT_SVH

// A condition that must never hold outside reset.
`define URRM_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion failed");

// An antecedent that implies a consequent in the next cycle.
`define URRM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: design/urrm_pkg.sv
// ----------------------------------------------------------------------------
// urrm_pkg
// Shared constants and types of the uniform range rejection mapper.
// ----------------------------------------------------------------------------
package urrm_pkg;

  // Default datapath width and the fixed width of the port fields.
  localparam int WORD_BITS_DEF = 64;
  localparam int FIELD_W       = 64;

  // Configuration register indexes.
  localparam int              CFG_IDX_W     = 2;
  localparam [CFG_IDX_W-1:0]  CFG_RANGE_MIN = 2'd0;
  localparam [CFG_IDX_W-1:0]  CFG_RANGE_MAX = 2'd1;

  // Status of the configuration unit as seen by the datapath.
  typedef struct packed {
    logic busy;        // scale and limit are being recomputed
    logic full_range;  // the range covers every word
  } cfg_status_t;

endpackage

// File: design/uniform_range_rejection_mapper_core.sv
// Uniform range rejection mapper.
// Input channel: one raw random word per beat (in_valid_i / in_ready_o).
// Output channel: one mapped value per accepted word (out_valid_o / out_ready_i).
// Outside full range, a word at or above the limit is dropped and gives no output beat.
// Configuration: write cfg_wdata_i to register cfg_idx_i (0 = min, 1 = max)
// with cfg_we_i high. Each write starts an iterative division that
// derives scale and limit; in_ready_o stays low until it finishes.
// A word passes the input register, which loads on the accepting edge,
// then one divider stage per quotient bit and the offset adder register.
// Throughput: one word per cycle while in_ready_o is high; the whole pipeline advances together.
// Reset: the range is the full word, so every word passes unchanged.
// A stalled receiver freezes the whole pipeline; no beat is lost or repeated.
// ----------------------------------------------------------------------------
// uniform_range_rejection_mapper_core
// Top level: input register, pipelined divider and output register.
// ----------------------------------------------------------------------------
`include "uniform_range_rejection_mapper_core_assert.svh"

module uniform_range_rejection_mapper_core #(
  parameter int WORD_BITS = urrm_pkg::WORD_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [urrm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [urrm_pkg::FIELD_W-1:0]   cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [urrm_pkg::FIELD_W-1:0]   random_word_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [urrm_pkg::FIELD_W-1:0]   mapped_value_o
);
  import urrm_pkg::*;

  cfg_status_t          status;
  logic [WORD_BITS-1:0] scale, limit, lo;
  logic                 adv, in_v_q, out_v_q;
  logic [WORD_BITS-1:0] in_word_q, in_word, sum;
  logic [FIELD_W-1:0]   out_val_q;

  logic                 st_v   [WORD_BITS+1];
  logic [WORD_BITS-1:0] st_num [WORD_BITS+1];
  logic [WORD_BITS-1:0] st_rem [WORD_BITS+1];
  logic [WORD_BITS-1:0] st_quo [WORD_BITS+1];

  urrm_cfg #(.WORD_BITS(WORD_BITS)) u_cfg (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .status_o(status), .scale_o(scale), .limit_o(limit), .lo_o(lo)
  );

  // The whole pipeline moves whenever the output register can take a beat.
  assign adv        = !out_v_q || out_ready_i;
  assign in_ready_o = adv && !status.busy;
  assign in_word    = random_word_i[WORD_BITS-1:0];

  // Input register; rejected words enter as bubbles.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (adv) begin
      in_v_q <= in_valid_i && in_ready_o && (status.full_range || in_word < limit);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_word_q <= in_word;
    end
  end

  assign st_v[0]   = in_v_q;
  assign st_num[0] = in_word_q;
  assign st_rem[0] = '0;
  assign st_quo[0] = '0;

  // One divider stage per quotient bit, most significant first.
  for (genvar g = 0; g < WORD_BITS; g++) begin : g_div
    urrm_div_stage #(.WORD_BITS(WORD_BITS), .BIT_IDX(WORD_BITS - 1 - g)) u_stage (
      .clk_i, .rst_ni, .en_i(adv), .div_i(scale),
      .valid_i(st_v[g]), .num_i(st_num[g]), .rem_i(st_rem[g]), .quo_i(st_quo[g]),
      .valid_o(st_v[g+1]), .num_o(st_num[g+1]), .rem_o(st_rem[g+1]),
      .quo_o(st_quo[g+1])
    );
  end

  // Output register adds the range minimum.
  assign sum = st_quo[WORD_BITS] + lo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= st_v[WORD_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_val_q <= FIELD_W'(sum);
    end
  end

  assign out_valid_o    = out_v_q;
  assign mapped_value_o = out_val_q;

  // No word is taken while scale and limit are being recomputed.
  `URRM_ASSERT_NEVER(a_busy_no_ready, clk_i, rst_ni, status.busy && in_ready_o)
  // Results never carry bits above the word width.
  `URRM_ASSERT_NEVER(a_out_width, clk_i, rst_ni,
                     out_valid_o && ((mapped_value_o >> WORD_BITS) != '0))
  // A result held back by the receiver is still there in the next cycle.
  `URRM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
                    out_valid_o && $stable(mapped_value_o))

endmodule

// File: design/urrm_cfg.sv
// ----------------------------------------------------------------------------
// urrm_cfg
// Range registers and an iterative divider that derives scale and limit.
// ----------------------------------------------------------------------------
module urrm_cfg #(
  parameter int WORD_BITS = urrm_pkg::WORD_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [urrm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [urrm_pkg::FIELD_W-1:0]        cfg_wdata_i,
  output urrm_pkg::cfg_status_t               status_o,
  output logic [WORD_BITS-1:0]                scale_o,
  output logic [WORD_BITS-1:0]                limit_o,
  output logic [WORD_BITS-1:0]                lo_o
);
  import urrm_pkg::*;

  localparam int             CW   = $clog2(WORD_BITS);
  localparam [WORD_BITS-1:0] MASK = {WORD_BITS{1'b1}};

  logic [WORD_BITS-1:0] lo_q, hi_q, rem_q, quo_q, scale_q, limit_q;
  logic [CW-1:0]        cnt_q;
  logic                 busy_q, full_q;
  logic [WORD_BITS-1:0] span, rem_d, quo_d;
  logic [WORD_BITS:0]   trial, diff;
  logic                 ge, last;

  // One restoring step of all-ones divided by the span.
  always_comb begin
    span  = hi_q - lo_q + WORD_BITS'(1);
    trial = {rem_q, 1'b1};
    diff  = trial - {1'b0, span};
    ge    = trial >= {1'b0, span};
    rem_d = ge ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
    quo_d = {quo_q[WORD_BITS-2:0], ge};
    last  = cnt_q == CW'(WORD_BITS - 1);
  end

  // Register writes restart the division; the result lands on the last step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q    <= '0;
      hi_q    <= MASK;
      busy_q  <= 1'b0;
      full_q  <= 1'b1;
      cnt_q   <= '0;
      rem_q   <= '0;
      quo_q   <= '0;
      scale_q <= WORD_BITS'(1);
      limit_q <= MASK;
    end else if (cfg_we_i && (cfg_idx_i == CFG_RANGE_MIN || cfg_idx_i == CFG_RANGE_MAX)) begin
      if (cfg_idx_i == CFG_RANGE_MIN) begin
        lo_q <= cfg_wdata_i[WORD_BITS-1:0];
      end else begin
        hi_q <= cfg_wdata_i[WORD_BITS-1:0];
      end
      busy_q <= 1'b1;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      cnt_q <= cnt_q + CW'(1);
      if (last) begin
        busy_q  <= 1'b0;
        full_q  <= span == '0;
        scale_q <= (span == '0) ? WORD_BITS'(1) : quo_d;
        limit_q <= MASK - rem_d;
      end
    end
  end

  assign status_o.busy       = busy_q;
  assign status_o.full_range = full_q;
  assign scale_o             = scale_q;
  assign limit_o             = limit_q;
  // In full range the scale is one and the offset zero, so words pass unchanged.
  assign lo_o                = full_q ? '0 : lo_q;

endmodule

// File: design/urrm_div_stage.sv
// ----------------------------------------------------------------------------
// urrm_div_stage
// One registered restoring-division stage that settles one quotient bit.
// ----------------------------------------------------------------------------
module urrm_div_stage #(
  parameter int WORD_BITS = 64,
  parameter int BIT_IDX   = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic [WORD_BITS-1:0] div_i,
  input  logic                 valid_i,
  input  logic [WORD_BITS-1:0] num_i,
  input  logic [WORD_BITS-1:0] rem_i,
  input  logic [WORD_BITS-1:0] quo_i,
  output logic                 valid_o,
  output logic [WORD_BITS-1:0] num_o,
  output logic [WORD_BITS-1:0] rem_o,
  output logic [WORD_BITS-1:0] quo_o
);
  logic                 valid_q;
  logic [WORD_BITS-1:0] num_q, rem_q, quo_q, rem_d, quo_d;
  logic [WORD_BITS:0]   trial, diff;
  logic                 ge;

  // Shift in the next dividend bit and subtract when it fits.
  always_comb begin
    trial          = {rem_i, num_i[BIT_IDX]};
    diff           = trial - {1'b0, div_i};
    ge             = trial >= {1'b0, div_i};
    rem_d          = ge ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
    quo_d          = quo_i;
    quo_d[BIT_IDX] = ge;
  end

  // Valid bit with reset; payload without.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q <= num_i;
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign valid_o = valid_q;
  assign num_o   = num_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;

endmodule

// File: sim/tb_uniform_range_rejection_mapper_core.sv
// ----------------------------------------------------------------------------
// Range mapper regression bench
// Sends raw random words through uniform_range_rejection_mapper_core under
// several range settings and random idling on both sides. A scoreboard
// predicts which words survive rejection and what value each one maps to,
// and compares every output beat with the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb_uniform_range_rejection_mapper_core;
  timeunit 1ns;
  timeprecision 1ps;

  import urrm_pkg::*;

  localparam int          WB        = 64;
  localparam int          SETTLE    = 2 * WB + 16;
  localparam int          MAX_CYC   = 400000;
  localparam bit [WB-1:0] ALL_ONES  = '1;
  localparam bit [CFG_IDX_W-1:0] CFG_UNUSED_A = 2'd2;
  localparam bit [CFG_IDX_W-1:0] CFG_UNUSED_B = 2'd3;

  // Predicts mapped values and holds the ones still owed by the block.
  class range_scoreboard;
    bit [WB-1:0] lo;
    bit [WB-1:0] hi;
    bit [WB-1:0] owed_values[$];
    int          fails;

    function new();
      lo    = '0;
      hi    = ALL_ONES;
      fails = 0;
    endfunction

    function void write_reg(bit [CFG_IDX_W-1:0] idx, bit [WB-1:0] val);
      if (idx == CFG_RANGE_MIN) lo = val;
      else if (idx == CFG_RANGE_MAX) hi = val;
    endfunction

    // Applies the rejection rule to one accepted word.
    function void note_word(bit [WB-1:0] w);
      bit [WB-1:0] span;
      bit [WB-1:0] scale;
      bit [WB-1:0] limit;
      span = hi - lo + 1'b1;
      if (span == '0) begin
        owed_values.push_back(w);
        return;
      end
      scale = ALL_ONES / span;
      limit = span * scale;
      if (w < limit) owed_values.push_back(w / scale + lo);
    endfunction

    function void check_value(bit [WB-1:0] got);
      bit [WB-1:0] want;
      if (owed_values.size() == 0) begin
        fails++;
        if (fails <= 10) $display("Unexpected output beat: got %h", got);
        return;
      end
      want = owed_values.pop_front();
      if (got !== want) begin
        fails++;
        if (fails <= 10) $display("Mismatch: expected %h, got %h", want, got);
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [FIELD_W-1:0]   cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [FIELD_W-1:0]   random_word_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [FIELD_W-1:0]   mapped_value_o;

  range_scoreboard sb;
  bit              no_idle;
  bit              hold_req;
  int              cycles;

  uniform_range_rejection_mapper_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .random_word_i (random_word_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .mapped_value_o(mapped_value_o)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Watchdog on total run length.
  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYC) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: random stalls per beat, plus one long hold on request.
  initial begin
    int wait_cyc;
    out_ready_i = 1'b0;
    wait_cyc    = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        sb.check_value(mapped_value_o);
        wait_cyc = no_idle ? 0 : $urandom_range(0, 12);
      end
      if (hold_req) begin
        hold_req = 1'b0;
        wait_cyc = 300;
      end
      if (wait_cyc > 0) begin
        wait_cyc--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic write_reg(bit [CFG_IDX_W-1:0] idx, bit [WB-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_range(bit [WB-1:0] lo, bit [WB-1:0] hi);
    write_reg(CFG_RANGE_MIN, lo);
    write_reg(CFG_RANGE_MAX, hi);
  endtask

  // Offers one word after a random gap and waits until it is accepted.
  task automatic send_word(bit [WB-1:0] w);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    random_word_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_word(w);
  endtask

  // Lets every owed value come out and the pipeline empty before a write.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.owed_values.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic bit [WB-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  task automatic random_phase(int n);
    bit [WB-1:0] lo;
    bit [WB-1:0] hi;
    case ($urandom_range(0, 5))
      0: begin lo = rand_word(); hi = lo + $urandom_range(0, 1000); end
      1: begin lo = rand_word(); hi = rand_word(); end
      2: begin lo = rand_word(); hi = lo; end
      3: begin lo = rand_word(); hi = lo - 1'b1; end
      4: begin lo = $urandom_range(0, 50); hi = (64'd1 << 63) + $urandom_range(0, 9); end
      default: begin lo = rand_word(); hi = lo + (rand_word() >> $urandom_range(0, 63)); end
    endcase
    set_range(lo, hi);
    for (int i = 0; i < n; i++) send_word(rand_word());
    drain();
  endtask

  initial begin
    sb            = new();
    no_idle       = 1'b0;
    hold_req      = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_RANGE_MIN;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    random_word_i = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (SETTLE) @(posedge clk_i);

    // Full range out of reset: words pass unchanged.
    send_word('0);
    send_word(ALL_ONES);
    send_word(64'h5555_5555_5555_5555);
    send_word(64'hAAAA_AAAA_AAAA_AAAA);
    drain();

    // Writes to unused indexes must leave the range alone.
    write_reg(CFG_UNUSED_A, 64'h1234);
    write_reg(CFG_UNUSED_B, ALL_ONES);
    send_word(64'h8000_0000_0000_0001);
    drain();

    // Span of one more than half the word: scale is one, limit sits mid-word.
    set_range('0, 64'h8000_0000_0000_0000);
    send_word(64'h8000_0000_0000_0000);
    send_word(64'h8000_0000_0000_0001);
    send_word(ALL_ONES);
    send_word('0);
    drain();

    // Single value: only the all-ones word is rejected.
    set_range(64'hDEAD_BEEF_0000_0001, 64'hDEAD_BEEF_0000_0001);
    send_word(ALL_ONES);
    send_word(ALL_ONES - 1'b1);
    send_word('0);
    drain();

    // Minimum above maximum wraps through the top of the word.
    set_range(ALL_ONES - 64'd1, 64'd1);
    send_word('0);
    send_word(ALL_ONES - 64'd4);
    send_word(ALL_ONES - 64'd3);
    send_word(ALL_ONES);
    drain();

    // Full range by wrap with a nonzero minimum.
    set_range(64'd7, 64'd6);
    send_word(64'd3);
    send_word(ALL_ONES);
    drain();

    // Back-to-back stretch with a long receiver hold to fill the pipeline.
    set_range('0, 64'd2);
    no_idle  = 1'b1;
    hold_req = 1'b1;
    for (int i = 0; i < 200; i++) send_word(rand_word());
    drain();

    // Random phases, a few of them without any idling.
    for (int p = 0; p < 12; p++) begin
      no_idle = (p % 4 == 3);
      random_phase(140);
    end
    no_idle = 1'b0;

    if (sb.fails == 0 && sb.owed_values.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
